// ===== design/skf_pkg.sv =====
package skf_pkg;

    localparam int DATA_W      = 32;
    localparam int GAIN_FRAC   = 16;
    localparam int GAIN_W      = GAIN_FRAC + 1;
    localparam int DEN_W       = DATA_W + 1;
    localparam int REM_W       = DATA_W + 2;
    localparam int PROD_W      = DEN_W + GAIN_FRAC;
    localparam int STEP_CNT_W  = $clog2(GAIN_W);
    localparam int OUT_FIELD_W = 3 * DATA_W + GAIN_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_FRAC;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC - 1);

    localparam logic [1:0] REG_PROCESS_NOISE      = 2'd0;
    localparam logic [1:0] REG_OBSERVATION_NOISE  = 2'd1;
    localparam logic [1:0] REG_INITIAL_ESTIMATE   = 2'd2;
    localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd3;

    localparam logic [DATA_W-1:0] RST_PROCESS_NOISE      = 32'd66;
    localparam logic [DATA_W-1:0] RST_OBSERVATION_NOISE  = 32'd65536;
    localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE   = 32'd0;
    localparam logic [DATA_W-1:0] RST_INITIAL_COVARIANCE = 32'd65536;

    typedef struct packed {
        logic [DATA_W-1:0] pp;
        logic [DEN_W-1:0]  denom;
        logic [DEN_W-1:0]  mag;
    } skf_gain_req_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [PROD_W-1:0] prod_mag;
        logic [PROD_W-1:0] prod_cov;
    } skf_gain_res_t;

endpackage

// ===== design/skf_gain_unit.sv =====
module skf_gain_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  skf_pkg::skf_gain_req_t req,
    output logic                  done,
    output skf_pkg::skf_gain_res_t res
);
    import skf_pkg::*;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(GAIN_FRAC);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W-1:0]      mag_reg;
    logic [DATA_W-1:0]     pp_reg;
    logic                  dz_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [GAIN_W-1:0]     k_reg;
    logic [PROD_W-1:0]     acc_mag_reg;
    logic [PROD_W-1:0]     acc_cov_reg;

    logic                  qbit;
    logic [REM_W-1:0]      rem_sub;
    logic [REM_W-1:0]      rem_next;
    logic [PROD_W-1:0]     acc_mag_next;
    logic [PROD_W-1:0]     acc_cov_next;

    // one quotient bit per step, msb first; both products follow the same bit
    always_comb
    begin
        qbit         = (rem_reg >= {1'b0, den_reg}) && !dz_reg;
        rem_sub      = qbit ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next     = {rem_sub[REM_W-2:0], 1'b0};
        acc_mag_next = {acc_mag_reg[PROD_W-2:0], 1'b0}
                     + (qbit ? PROD_W'(mag_reg) : '0);
        acc_cov_next = {acc_cov_reg[PROD_W-2:0], 1'b0}
                     + (qbit ? PROD_W'(pp_reg) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg     <= req.denom;
            mag_reg     <= req.mag;
            pp_reg      <= req.pp;
            dz_reg      <= (req.denom == '0);
            rem_reg     <= REM_W'(req.pp);
            k_reg       <= '0;
            acc_mag_reg <= '0;
            acc_cov_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg     <= rem_next;
            k_reg       <= {k_reg[GAIN_W-2:0], qbit};
            acc_mag_reg <= acc_mag_next;
            acc_cov_reg <= acc_cov_next;
        end
    end

    assign done         = done_reg;
    assign res.gain     = k_reg;
    assign res.prod_mag = acc_mag_reg;
    assign res.prod_cov = acc_cov_reg;

endmodule

// ===== design/scalar_kalman_filter.sv =====
// Scalar Kalman filter with a random-walk model, Q16.16 data and a Q1.16 gain.
// An accepted observation request passes through the prepare step, which forms
// the predicted covariance, denominator and innovation, then 17 steps of the
// shared shift-subtract unit that produces the gain one bit per cycle while
// accumulating both gain products, then the unit's done flag, and then the
// finish step, which rounds, saturates and loads the output register; the next
// request is taken only once the sequencer is back in idle, so a new observation
// is not taken before the last one is through. A restart request skips the gain
// unit and goes straight to the finish step, and is likewise not overlapped with
// the next request. A result that waits on the output holds the next one in the
// finish step and stalls the input until it leaves. A new request is taken
// while a result still waits on the output. Register writes only change the
// noise terms and the values loaded at the next restart.
module scalar_kalman_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [skf_pkg::DATA_W-1:0]           s_tdata,  // observation
    input  logic                                 s_tuser,  // restart
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // estimate, variance, gain_out, update_count, zero pad
    output logic [skf_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import skf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PREP   = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam int EST_W = DATA_W + 3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;

    logic [DATA_W-1:0]      q_reg;
    logic [DATA_W-1:0]      r_reg;
    logic [DATA_W-1:0]      init_est_reg;
    logic [DATA_W-1:0]      init_cov_reg;

    logic [DATA_W-1:0]      est_reg;
    logic [DATA_W-1:0]      cov_reg;
    logic [DATA_W-1:0]      count_reg;

    logic [DATA_W-1:0]      z_reg;
    logic                   restart_reg;
    logic [DATA_W-1:0]      pp_reg;
    logic                   neg_reg;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                   in_take;
    logic                   out_load;
    logic                   unit_start;
    logic                   unit_done;
    skf_gain_req_t          unit_req;
    skf_gain_res_t          unit_res;

    logic [DATA_W:0]        pp_sum;
    logic [DATA_W-1:0]      pp;
    logic [DEN_W-1:0]       innov;
    logic [PROD_W-1:0]      mag_round;
    logic [DEN_W-1:0]       mag_d;
    logic [EST_W-1:0]       est_sum;
    logic                   est_hi;
    logic                   est_lo;
    logic [DATA_W-1:0]      est_sat;
    logic [PROD_W-1:0]      cov_full;
    logic [DATA_W-1:0]      est_next;
    logic [DATA_W-1:0]      cov_next;
    logic [GAIN_W-1:0]      gain_next;
    logic [DATA_W-1:0]      count_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_take    = s_tvalid && s_tready;
    assign out_load   = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign unit_start = (state_reg == ST_PREP);

    // predict and innovation
    always_comb
    begin
        pp_sum         = {1'b0, cov_reg} + {1'b0, q_reg};
        pp             = pp_sum[DATA_W] ? '1 : pp_sum[DATA_W-1:0];
        innov          = {z_reg[DATA_W-1], z_reg} - {est_reg[DATA_W-1], est_reg};
        unit_req.pp    = pp;
        unit_req.denom = {1'b0, pp} + {1'b0, r_reg};
        unit_req.mag   = innov[DEN_W-1] ? (~innov + 1'b1) : innov;
    end

    skf_gain_unit u_gain (
        .clk   (clk),
        .rst_n (rst_n),
        .start (unit_start),
        .req   (unit_req),
        .done  (unit_done),
        .res   (unit_res)
    );

    // round, saturate, update
    always_comb
    begin
        mag_round = unit_res.prod_mag + ROUND_HALF;
        mag_d     = mag_round[PROD_W-1:GAIN_FRAC];
        est_sum   = {{(EST_W-DATA_W){est_reg[DATA_W-1]}}, est_reg}
                  + (neg_reg ? (~EST_W'(mag_d) + 1'b1) : EST_W'(mag_d));
        est_hi    = !est_sum[EST_W-1] && (est_sum[EST_W-2:DATA_W-1] != '0);
        est_lo    = est_sum[EST_W-1] && (est_sum[EST_W-2:DATA_W-1] != '1);
        if (est_hi)
            est_sat = {1'b0, {(DATA_W-1){1'b1}}};
        else if (est_lo)
            est_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            est_sat = est_sum[DATA_W-1:0];
        cov_full  = {1'b0, pp_reg, {GAIN_FRAC{1'b0}}} - unit_res.prod_cov + ROUND_HALF;

        if (restart_reg)
        begin
            est_next   = init_est_reg;
            cov_next   = init_cov_reg;
            gain_next  = '0;
            count_next = '0;
        end
        else
        begin
            est_next   = est_sat;
            cov_next   = cov_full[DATA_W+GAIN_FRAC-1:GAIN_FRAC];
            gain_next  = unit_res.gain;
            count_next = (count_reg == '1) ? count_reg : (count_reg + 1'b1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = s_tuser ? ST_FINISH : ST_PREP;
            end
            ST_PREP:
                state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (unit_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            q_reg        <= RST_PROCESS_NOISE;
            r_reg        <= RST_OBSERVATION_NOISE;
            init_est_reg <= RST_INITIAL_ESTIMATE;
            init_cov_reg <= RST_INITIAL_COVARIANCE;
            est_reg      <= RST_INITIAL_ESTIMATE;
            cov_reg      <= RST_INITIAL_COVARIANCE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROCESS_NOISE:      q_reg        <= cfg_data;
                    REG_OBSERVATION_NOISE:  r_reg        <= cfg_data;
                    REG_INITIAL_ESTIMATE:   init_est_reg <= cfg_data;
                    REG_INITIAL_COVARIANCE: init_cov_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                est_reg      <= est_next;
                cov_reg      <= cov_next;
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            z_reg       <= s_tdata;
            restart_reg <= s_tuser;
        end
        if (unit_start)
        begin
            pp_reg  <= pp;
            neg_reg <= innov[DEN_W-1];
        end
        if (out_load)
            m_tdata_reg <= OUT_TDATA_W'({count_next, gain_next, cov_next, est_next});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // gain unit finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> (state_reg == ST_DIVIDE))
        else $error("gain unit finished outside divide state");

    // gain never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_done |-> (unit_res.gain <= GAIN_ONE))
        else $error("gain above one");

    // updated covariance never exceeds the prediction
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !restart_reg) |-> (cov_next <= pp_reg))
        else $error("covariance grew on update");

    // restart result carries zero count and zero gain
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && restart_reg) |=>
            (m_tdata[3*DATA_W+GAIN_W-1:2*DATA_W] == '0))
        else $error("restart result not cleared");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import skf_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] estimate;
        logic [DATA_W-1:0] variance;
        logic [GAIN_W-1:0] gain;
        logic [DATA_W-1:0] count;
    } kf_update_t;

    class kalman_tracker;
        logic [DATA_W-1:0] q_noise;
        logic [DATA_W-1:0] r_noise;
        logic [DATA_W-1:0] init_est;
        logic [DATA_W-1:0] init_cov;
        logic [DATA_W-1:0] est;
        logic [DATA_W-1:0] cov;
        logic [GAIN_W-1:0] gain;
        logic [DATA_W-1:0] count;
        kf_update_t expected_updates[$];
        int failures;
        int checked;

        function new();
            q_noise = RST_PROCESS_NOISE;
            r_noise = RST_OBSERVATION_NOISE;
            init_est = RST_INITIAL_ESTIMATE;
            init_cov = RST_INITIAL_COVARIANCE;
            failures = 0;
            checked = 0;
            reload();
        endfunction

        function void reload();
            est = init_est;
            cov = init_cov;
            gain = '0;
            count = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_PROCESS_NOISE:      q_noise = val;
                REG_OBSERVATION_NOISE:  r_noise = val;
                REG_INITIAL_ESTIMATE:   init_est = val;
                REG_INITIAL_COVARIANCE: init_cov = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_updates.size();
        endfunction

        function void note_observation(logic [DATA_W-1:0] obs, logic restart_flag);
            logic [63:0] pp;
            logic [63:0] denom;
            logic [63:0] k;
            logic [63:0] mag;
            longint innov;
            longint x_next;
            kf_update_t upd;
            if (restart_flag)
                reload();
            else
            begin
                pp = {32'd0, cov} + {32'd0, q_noise};
                if (pp > 64'hffff_ffff)
                    pp = 64'hffff_ffff;
                denom = pp + {32'd0, r_noise};
                k = (denom != 0) ? (pp << GAIN_FRAC) / denom : 64'd0;
                innov = longint'($signed(obs)) - longint'($signed(est));
                mag = (innov < 0) ? 64'(-innov) : 64'(innov);
                mag = (mag * k + 64'd32768) >> GAIN_FRAC;
                x_next = longint'($signed(est)) + ((innov < 0) ? -longint'(mag) : longint'(mag));
                if (x_next > 64'sh7fff_ffff)
                    x_next = 64'sh7fff_ffff;
                if (x_next < -64'sh8000_0000)
                    x_next = -64'sh8000_0000;
                est = x_next[DATA_W-1:0];
                cov = 32'((((64'd65536 - k) * pp) + 64'd32768) >> GAIN_FRAC);
                gain = k[GAIN_W-1:0];
                if (count != '1)
                    count = count + 1;
            end
            upd.estimate = est;
            upd.variance = cov;
            upd.gain = gain;
            upd.count = count;
            expected_updates.push_back(upd);
        endfunction

        function void check_update(logic [OUT_TDATA_W-1:0] data);
            kf_update_t exp_upd;
            logic [DATA_W-1:0] got_est;
            logic [DATA_W-1:0] got_var;
            logic [GAIN_W-1:0] got_gain;
            logic [DATA_W-1:0] got_count;
            got_est = data[DATA_W-1:0];
            got_var = data[2*DATA_W-1:DATA_W];
            got_gain = data[2*DATA_W+GAIN_W-1:2*DATA_W];
            got_count = data[3*DATA_W+GAIN_W-1:2*DATA_W+GAIN_W];
            if (expected_updates.size() == 0)
            begin
                $error("result with no pending request: estimate %0d", $signed(got_est));
                failures++;
                return;
            end
            exp_upd = expected_updates.pop_front();
            checked++;
            if (got_est !== exp_upd.estimate)
            begin
                $error("estimate: expected %0d, got %0d",
                       $signed(exp_upd.estimate), $signed(got_est));
                failures++;
            end
            if (got_var !== exp_upd.variance)
            begin
                $error("variance: expected %0d, got %0d", exp_upd.variance, got_var);
                failures++;
            end
            if (got_gain !== exp_upd.gain)
            begin
                $error("gain_out: expected %0d, got %0d", exp_upd.gain, got_gain);
                failures++;
            end
            if (got_count !== exp_upd.count)
            begin
                $error("update_count: expected %0d, got %0d", exp_upd.count, got_count);
                failures++;
            end
        endfunction

        function void final_check();
            if (expected_updates.size() != 0)
            begin
                $error("%0d expected results never arrived", expected_updates.size());
                failures++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [DATA_W-1:0]      cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [DATA_W-1:0]      s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    kalman_tracker tracker;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_req;
    int n_observations;
    int n_restarts;
    int n_settings;

    scalar_kalman_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    task automatic send_item(input logic [DATA_W-1:0] obs, input logic restart_flag);
        s_tvalid <= 1'b1;
        s_tdata <= obs;
        s_tuser <= restart_flag;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_observation(obs, restart_flag);
        if (restart_flag)
            n_restarts++;
        else
            n_observations++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
            begin
                s_tdata <= $urandom;
                s_tuser <= 1'($urandom);
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r,
                              input logic [DATA_W-1:0] e, input logic [DATA_W-1:0] c);
        logic [1:0] idx [4];
        logic [DATA_W-1:0] vals [4];
        idx[0] = REG_PROCESS_NOISE;
        idx[1] = REG_OBSERVATION_NOISE;
        idx[2] = REG_INITIAL_ESTIMATE;
        idx[3] = REG_INITIAL_COVARIANCE;
        vals[0] = q;
        vals[1] = r;
        vals[2] = e;
        vals[3] = c;
        wait_idle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            tracker.write_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [DATA_W-1:0] pick_noise();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return DATA_W'($urandom_range(1, 256));
            3: return DATA_W'($urandom_range(1 << 12, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    // receiver: random backpressure plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_update(m_tdata);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] obs;
        int drain;
        tracker = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 47;
        hold_off_req = 1'b0;
        n_observations = 0;
        n_restarts = 0;
        n_settings = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'h5a5a_5a5a, 1'b1);
        send_item(32'h0001_0000, 1'b0);

        // zero observation noise, gain of one
        set_config('0, '0, 32'h7fff_ffff, '1);
        send_item(32'ha5a5_a5a5, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h7fff_ffff, 1'b0);

        // predicted covariance saturates
        set_config('1, '1, 32'h8000_0000, '1);
        send_item(32'hffff_ffff, 1'b1);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h0000_0000, 1'b0);

        // zero denominator
        set_config('0, '0, 32'h1234_5678, '0);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'h7fff_ffff, 1'b0);
        send_item(32'h8000_0000, 1'b0);

        set_config(32'd66, 32'd65536, 32'hffff_0000, 32'd65536);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'hffff_ffff, 1'b0);

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 47;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_config(pick_noise(), pick_noise(), $urandom, pick_noise());
            if (phase == 1)
                hold_off_req = 1'b1;
            base = $urandom;
            send_item($urandom, 1'b1);
            for (int n = 0; n < 162; n++)
            begin
                case ($urandom_range(19))
                    0: obs = 32'h7fff_ffff;
                    1: obs = 32'h8000_0000;
                    2, 3, 4: obs = $urandom;
                    5:
                    begin
                        base = $urandom;
                        obs = base;
                    end
                    default: obs = base + DATA_W'($urandom_range(0, 1 << 19)) - (1 << 18);
                endcase
                if ($urandom_range(99) < 3)
                    send_item($urandom, 1'b1);
                else
                    send_item(obs, 1'b0);
            end
        end

        s_tvalid <= 1'b0;
        drain = 0;
        while (tracker.pending() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (30) @(posedge clk);
        tracker.final_check();
        $display("covered %0d observations and %0d restarts over %0d register settings",
                 n_observations, n_restarts, n_settings);
        $display("%0d results checked, %0d mismatches", tracker.checked, tracker.failures);
        if (tracker.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
